### design/hist_eq_pkg.sv
package hist_eq_pkg;

  // Fixed field widths of the pixel stream and the configuration port.
  localparam int PIX_W  = 8;
  localparam int OUT_W  = 8;
  localparam int CNT_W  = 25;
  localparam int REG_W  = 13;
  localparam int APB_DW = 32;
  localparam int ADDR_W = 3;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_COUNT = 2'd1,
    OP_BUILD = 2'd2,
    OP_MAP   = 2'd3
  } op_t;

  // Register index, taken from paddr bit 2.
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

endpackage

### design/hist_eq_ram.sv
module hist_eq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read at the address being written returns the old content.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/hist_eq_div.sv
module hist_eq_div import hist_eq_pkg::*; #(
  parameter int NUM_W = 35,
  parameter int DEN_W = 34
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [OUT_W-1:0] quot
);

  localparam int R_W    = DEN_W + 1;
  localparam int E_W    = (NUM_W > DEN_W + OUT_W) ? NUM_W : DEN_W + OUT_W;
  localparam int STEP_W = (OUT_W > 1) ? $clog2(OUT_W) : 1;

  typedef enum logic [1:0] {DV_IDLE, DV_CHECK, DV_STEP} dv_state_t;

  dv_state_t         state;
  logic [NUM_W-1:0]  num_q;
  logic [DEN_W-1:0]  den_q;
  logic [R_W-1:0]    rem;
  logic [OUT_W-1:0]  low;
  logic [STEP_W-1:0] step;
  logic [R_W-1:0]    trial;
  logic              fits;

  // One quotient bit per cycle; the remainder always stays below den_q.
  assign trial = {rem[DEN_W-1:0], low[OUT_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DV_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        DV_IDLE: begin
          if (start) begin
            num_q <= num;
            den_q <= den;
            state <= DV_CHECK;
          end
        end
        DV_CHECK: begin
          // A quotient that does not fit in the output saturates to all ones.
          if (E_W'(num_q) >= E_W'({den_q, {OUT_W{1'b0}}})) begin
            quot  <= '1;
            done  <= 1'b1;
            state <= DV_IDLE;
          end else begin
            rem   <= R_W'(num_q >> OUT_W);
            low   <= num_q[OUT_W-1:0];
            step  <= '0;
            state <= DV_STEP;
          end
        end
        DV_STEP: begin
          low <= low << 1;
          if (fits) begin
            rem  <= trial - {1'b0, den_q};
            quot <= {quot[OUT_W-2:0], 1'b1};
          end else begin
            rem  <= trial;
            quot <= {quot[OUT_W-2:0], 1'b0};
          end
          step <= step + 1'b1;
          if (step == STEP_W'(OUT_W - 1)) begin
            done  <= 1'b1;
            state <= DV_IDLE;
          end
        end
        default: begin
          state <= DV_IDLE;
        end
      endcase
    end
  end

endmodule

### design/histogram_equalizer_core.sv
// Channel      | Direction | Payload
// s_axis_*     | in        | tuser = opcode [1:0], tdata = pixel_value [7:0]
// m_axis_*     | out       | tdata = mapped_value [7:0]; one result per map request
// APB          | in/out    | reg 0 image_width @0x0, reg 1 image_height @0x4
//
// Count and map requests are taken one per cycle while s_axis_tready is high; a map
// result is registered at the map memory read and again at the output register. A clear
// request zeroes the bin memory; a build runs the bin memory read and the bit-serial
// divider, bin by bin. After reset a pass zeroes both memories before requests are taken.
// A stalled output holds up to two results; s_axis_tready drops once both places are
// claimed, counting a map result still one stage short of the output, and during sweeps.
module histogram_equalizer_core import hist_eq_pkg::*; #(
  parameter int GRAY_LEVELS = 256,
  parameter int MAX_SIDE    = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] pixel_value
  input  logic [1:0]        s_axis_tuser,   // [1:0] opcode
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,   // [7:0] mapped_value
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int BIN_W  = (GRAY_LEVELS > 1) ? $clog2(GRAY_LEVELS) : 1;
  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int N_W    = 2 * SIDE_W;
  localparam int NUM_W  = ((CNT_W + OUT_W > N_W - 1) ? CNT_W + OUT_W : N_W - 1) + 1;
  localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(GRAY_LEVELS - 1);

  typedef enum logic [2:0] {
    ST_INIT, ST_IDLE, ST_CLEAR, ST_B_SETUP, ST_B_READ, ST_B_ACC, ST_B_START, ST_B_WAIT
  } state_t;

  // Configuration registers.
  logic [REG_W-1:0] image_width;
  logic [REG_W-1:0] image_height;

  // Sequencer state.
  state_t           state;
  logic [BIN_W-1:0] idx;
  logic [CNT_W-1:0] running_total;
  logic [N_W-1:0]   n;

  // Stage after acceptance, where memory read data is available.
  logic             s1_count;
  logic             s1_map;
  logic             s1_in_range;
  logic [BIN_W-1:0] s1_idx;

  // Last bin written by a count, forwarded over the memory's read-during-write.
  logic             fwd_valid;
  logic [BIN_W-1:0] fwd_addr;
  logic [CNT_W-1:0] fwd_data;

  // Output register and skid stage.
  logic             out_valid;
  logic [OUT_W-1:0] out_data;
  logic             skid_valid;
  logic [OUT_W-1:0] skid_data;

  // Memory ports.
  logic             bin_we;
  logic [BIN_W-1:0] bin_waddr;
  logic [CNT_W-1:0] bin_wdata;
  logic [BIN_W-1:0] bin_raddr;
  logic [CNT_W-1:0] bin_rdata;
  logic             map_we;
  logic [BIN_W-1:0] map_waddr;
  logic [OUT_W-1:0] map_wdata;
  logic [OUT_W-1:0] map_rdata;

  // Divider.
  logic             div_start;
  logic             div_done;
  logic [OUT_W-1:0] div_quot;
  logic [NUM_W-1:0] div_num;

  logic             cfg_wr;
  logic             in_acc;
  logic             pop;
  logic             room;
  op_t              op;
  logic             in_range;
  logic [BIN_W-1:0] px_idx;
  logic [CNT_W-1:0] bin_base;
  logic [CNT_W-1:0] bin_inc;
  logic [CNT_W:0]   cum_sum;
  logic [CNT_W-1:0] cum_next;
  logic [SIDE_W-1:0] side_w;
  logic [SIDE_W-1:0] side_h;
  logic [N_W-1:0]   n_prod;
  logic [OUT_W-1:0] push_data;

  // A side of zero counts as one, a side beyond MAX_SIDE as MAX_SIDE.
  function automatic logic [SIDE_W-1:0] side_used(input logic [REG_W-1:0] v);
    if (v == '0) begin
      return SIDE_W'(1);
    end
    if (32'(v) > MAX_SIDE) begin
      return SIDE_W'(MAX_SIDE);
    end
    return SIDE_W'(v);
  endfunction

  // APB register file; every access completes in its access cycle.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= REG_W'(1);
      image_height <= REG_W'(1);
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_IMAGE_WIDTH:  image_width  <= pwdata[REG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[REG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_IMAGE_WIDTH:  prdata = APB_DW'(image_width);
      REG_IMAGE_HEIGHT: prdata = APB_DW'(image_height);
      default:          prdata = '0;
    endcase
  end

  // Input decode.
  assign op       = op_t'(s_axis_tuser);
  assign in_range = 32'(s_axis_tdata) < GRAY_LEVELS;
  assign px_idx   = BIN_W'(s_axis_tdata);

  // Requests are taken only while no sweep runs and the output side can hold
  // every map result still in flight, counting one that leaves this cycle.
  assign pop  = out_valid && m_axis_tready;
  assign room = ({1'b0, out_valid} + {1'b0, skid_valid} + {1'b0, s1_map})
                <= (2'd1 + {1'b0, pop});
  assign s_axis_tready = (state == ST_IDLE) && room;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Count: read-modify-write of one bin, saturating at the top of the count.
  assign bin_base = (fwd_valid && (fwd_addr == s1_idx)) ? fwd_data : bin_rdata;
  assign bin_inc  = (bin_base == '1) ? bin_base : bin_base + 1'b1;

  // Build: running cumulative sum, saturating.
  assign cum_sum  = {1'b0, running_total} + {1'b0, bin_rdata};
  assign cum_next = cum_sum[CNT_W] ? '1 : cum_sum[CNT_W-1:0];

  assign side_w = side_used(image_width);
  assign side_h = side_used(image_height);
  assign n_prod = side_w * side_h;

  // Numerator cum*(2^OUT_W - 1) + floor(N/2); the scale is a shift and subtract.
  assign div_num = NUM_W'({running_total, {OUT_W{1'b0}}}) - NUM_W'(running_total)
                   + NUM_W'(n >> 1);
  assign div_start = (state == ST_B_START);

  assign push_data = s1_in_range ? map_rdata : '0;

  always_comb begin
    bin_raddr = (state == ST_B_READ) ? idx : px_idx;
    bin_we    = 1'b0;
    bin_waddr = s1_idx;
    bin_wdata = bin_inc;
    if (state == ST_INIT || state == ST_CLEAR) begin
      bin_we    = 1'b1;
      bin_waddr = idx;
      bin_wdata = '0;
    end else if (s1_count) begin
      bin_we = 1'b1;
    end
  end

  always_comb begin
    map_we    = 1'b0;
    map_waddr = idx;
    map_wdata = div_quot;
    if (state == ST_INIT) begin
      map_we    = 1'b1;
      map_wdata = '0;
    end else if (state == ST_B_WAIT && div_done) begin
      map_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_INIT;
      idx           <= '0;
      running_total <= '0;
      s1_count      <= 1'b0;
      s1_map        <= 1'b0;
      fwd_valid     <= 1'b0;
      out_valid     <= 1'b0;
      skid_valid    <= 1'b0;
    end else begin
      // Pipeline stage after acceptance.
      s1_count    <= in_acc && (op == OP_COUNT) && in_range;
      s1_map      <= in_acc && (op == OP_MAP);
      s1_in_range <= in_range;
      s1_idx      <= px_idx;
      fwd_valid   <= s1_count;
      fwd_addr    <= s1_idx;
      fwd_data    <= bin_inc;

      // Output register with a skid stage behind it, kept in order.
      if (pop || !out_valid) begin
        if (skid_valid) begin
          out_data   <= skid_data;
          skid_valid <= s1_map;
          skid_data  <= push_data;
        end else begin
          out_valid <= s1_map;
          out_data  <= push_data;
        end
      end else if (s1_map) begin
        skid_valid <= 1'b1;
        skid_data  <= push_data;
      end

      case (state)
        ST_INIT, ST_CLEAR: begin
          if (idx == LAST_BIN) begin
            idx   <= '0;
            state <= ST_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            case (op)
              OP_CLEAR: begin
                idx           <= '0;
                running_total <= '0;
                state         <= ST_CLEAR;
              end
              OP_BUILD: begin
                state <= ST_B_SETUP;
              end
              default: begin
              end
            endcase
          end
        end
        ST_B_SETUP: begin
          n             <= n_prod;
          running_total <= '0;
          idx           <= '0;
          state         <= ST_B_READ;
        end
        ST_B_READ: begin
          state <= ST_B_ACC;
        end
        ST_B_ACC: begin
          running_total <= cum_next;
          state         <= ST_B_START;
        end
        ST_B_START: begin
          state <= ST_B_WAIT;
        end
        ST_B_WAIT: begin
          if (div_done) begin
            if (idx == LAST_BIN) begin
              idx   <= '0;
              state <= ST_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= ST_B_READ;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  hist_eq_ram #(
    .WIDTH (CNT_W),
    .DEPTH (GRAY_LEVELS)
  ) u_bin_ram (
    .clk   (clk),
    .we    (bin_we),
    .waddr (bin_waddr),
    .wdata (bin_wdata),
    .raddr (bin_raddr),
    .rdata (bin_rdata)
  );

  hist_eq_ram #(
    .WIDTH (OUT_W),
    .DEPTH (GRAY_LEVELS)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (px_idx),
    .rdata (map_rdata)
  );

  hist_eq_div #(
    .NUM_W (NUM_W),
    .DEN_W (N_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (n),
    .done  (div_done),
    .quot  (div_quot)
  );

  // The skid stage fills only behind a held output register.
  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds a result while the output register is empty");

  // A clear request starts the bin sweep in the next cycle.
  a_clear_start: assert property (@(posedge clk) disable iff (rst)
    (in_acc && op == OP_CLEAR) |=> (state == ST_CLEAR))
    else $error("clear request did not start the sweep");

  // A count write never competes with a sweep for the bin write port.
  a_bin_port: assert property (@(posedge clk) disable iff (rst)
    !(s1_count && (state == ST_CLEAR || state == ST_INIT)))
    else $error("count write collides with a bin sweep");

  // The divider finishes only while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_B_WAIT))
    else $error("divider result arrived outside the build wait");

endmodule
